[src/wnf_pkg.sv]
`default_nettype none
package wnf_pkg;

	// fixed field widths
	localparam int FRAC_W = 16;
	localparam int DIFF_W = 17;
	localparam int SQ_W   = 32;
	localparam int SUM_W  = 34;
	localparam int K_W    = 5;
	localparam int NORM_W = 17;
	localparam int TAN_W  = 18;

	// square root and divider sizes
	localparam int RAD_W     = 62;
	localparam int ROOT_W    = 31;
	localparam int QUO_W     = 17;
	localparam int NUM_W     = QUO_W + ROOT_W + 1;
	localparam int NUM_LANES = 3;

	// Q.15 limits
	localparam int ONE_Q15 = 32768;
	localparam int NMAX    = 32768;
	localparam int TMAX    = 65536;

	// product width and rounded width
	localparam int PROD_W = 36;
	localparam int RND_W  = 22;

	// sideband carried through the square root
	typedef struct packed {
		logic [2:0][FRAC_W-1:0] mag;
		logic [2:0]             neg;
		logic [K_W-1:0]         k;
		logic                   zero;
	} side_a_t;

	// sideband carried through the divider
	typedef struct packed {
		logic [2:0] neg;
		logic       zero;
	} side_b_t;

	// p / 2^15, rounded half away from zero
	function automatic logic signed [RND_W-1:0] rq15(input logic signed [PROD_W-1:0] p);
		logic [PROD_W-1:0] m;
		logic [RND_W-1:0]  r;
		m = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
		r = RND_W'((m + PROD_W'(16384)) >> 15);
		return p[PROD_W-1] ? -$signed(r) : $signed(r);
	endfunction

	// saturate to the tangent range
	function automatic logic signed [TAN_W-1:0] sat_t(input logic signed [RND_W-1:0] v);
		if (v > RND_W'(TMAX)) return TAN_W'(TMAX);
		if (v < -$signed(RND_W'(TMAX))) return -$signed(TAN_W'(TMAX));
		return TAN_W'(v);
	endfunction

endpackage
`default_nettype wire

[src/wnf_sqrt.sv]
`default_nettype none
// Pipelined integer square root, one result bit per stage.
module wnf_sqrt #(
	parameter int TAG_W = 1
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_vld,
	input  wire logic [wnf_pkg::RAD_W-1:0]  rad,
	input  wire logic [TAG_W-1:0]           in_tag,
	output logic                            out_vld,
	output logic [wnf_pkg::ROOT_W-1:0]      root,
	output logic [TAG_W-1:0]                out_tag
);
	localparam int RW    = wnf_pkg::ROOT_W;
	localparam int AW    = wnf_pkg::RAD_W;
	localparam int REM_W = RW + 3;

	logic             vld_s  [0:RW];
	logic [REM_W-1:0] rem_s  [0:RW];
	logic [RW-1:0]    root_s [0:RW];
	logic [AW-1:0]    rad_s  [0:RW];
	logic [TAG_W-1:0] tag_s  [0:RW];

	assign vld_s[0]  = in_vld;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign rad_s[0]  = rad;
	assign tag_s[0]  = in_tag;

	for (genvar i = 0; i < RW; i++) begin : g_stage
		logic [REM_W-1:0] rem_sh;
		logic [REM_W-1:0] trial;
		logic             ge;

		// bring down two radicand bits, try root*4+1
		always_comb begin
			rem_sh = {rem_s[i][REM_W-3:0], rad_s[i][AW-1 -: 2]};
			trial  = REM_W'({root_s[i], 2'b01});
			ge     = rem_sh >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[i+1]  <= ge ? rem_sh - trial : rem_sh;
			root_s[i+1] <= {root_s[i][RW-2:0], ge};
			rad_s[i+1]  <= {rad_s[i][AW-3:0], 2'b00};
			tag_s[i+1]  <= tag_s[i];
		end
	end

	assign out_vld = vld_s[RW];
	assign root    = root_s[RW];
	assign out_tag = tag_s[RW];

endmodule
`default_nettype wire

[src/wnf_div.sv]
`default_nettype none
// Pipelined restoring divider, three lanes over one divisor, one quotient bit per stage.
module wnf_div #(
	parameter int TAG_W = 1
) (
	input  wire logic                                                clk,
	input  wire logic                                                arst_n,
	input  wire logic                                                in_vld,
	input  wire logic [wnf_pkg::NUM_LANES-1:0][wnf_pkg::NUM_W-1:0]   num,
	input  wire logic [wnf_pkg::ROOT_W-1:0]                          den,
	input  wire logic [TAG_W-1:0]                                    in_tag,
	output logic                                                     out_vld,
	output logic [wnf_pkg::NUM_LANES-1:0][wnf_pkg::QUO_W-1:0]        quot,
	output logic [TAG_W-1:0]                                         out_tag
);
	localparam int QW    = wnf_pkg::QUO_W;
	localparam int DW    = wnf_pkg::ROOT_W;
	localparam int LN    = wnf_pkg::NUM_LANES;
	localparam int REM_W = DW + 1;

	logic                          vld_s [0:QW];
	logic [LN-1:0][REM_W-1:0]      rem_s [0:QW];
	logic [LN-1:0][QW-1:0]         qb_s  [0:QW];
	logic [DW-1:0]                 den_s [0:QW];
	logic [TAG_W-1:0]              tag_s [0:QW];

	// upper numerator bits start the remainder, lower bits shift in
	always_comb begin
		for (int l = 0; l < LN; l++) begin
			rem_s[0][l] = num[l][QW+REM_W-1:QW];
			qb_s[0][l]  = num[l][QW-1:0];
		end
	end
	assign vld_s[0] = in_vld;
	assign den_s[0] = den;
	assign tag_s[0] = in_tag;

	for (genvar i = 0; i < QW; i++) begin : g_stage
		logic [LN-1:0][REM_W-1:0] rem_sh;
		logic [LN-1:0]            ge;

		always_comb begin
			for (int l = 0; l < LN; l++) begin
				rem_sh[l] = {rem_s[i][l][REM_W-2:0], qb_s[i][l][QW-1]};
				ge[l]     = rem_sh[l] >= REM_W'(den_s[i]);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			for (int l = 0; l < LN; l++) begin
				rem_s[i+1][l] <= ge[l] ? rem_sh[l] - REM_W'(den_s[i]) : rem_sh[l];
				qb_s[i+1][l]  <= {qb_s[i][l][QW-2:0], ge[l]};
			end
			den_s[i+1] <= den_s[i];
			tag_s[i+1] <= tag_s[i];
		end
	end

	assign out_vld = vld_s[QW];
	assign quot    = qb_s[QW];
	assign out_tag = tag_s[QW];

endmodule
`default_nettype wire

[src/wall_normal_and_frame_top.sv]
`default_nettype none
// Wall normal and tangent frame from six face fractions. One item is taken
// every clock cycle (busy stays low) and its result is strobed on done for a
// single cycle once it has passed through five front stages (difference,
// squares, sum, shift search, normalising shift), a 31-stage square root, one
// numerator stage, a 17-stage three-lane divider and five frame stages. The
// receiver cannot stall; the result ports are only meaningful while done is
// high and change freely in other cycles.
module wall_normal_and_frame_top #(
	parameter int DIMENSIONS = 3
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic [15:0]         frac_x_low,
	input  wire logic [15:0]         frac_x_high,
	input  wire logic [15:0]         frac_y_low,
	input  wire logic [15:0]         frac_y_high,
	input  wire logic [15:0]         frac_z_low,
	input  wire logic [15:0]         frac_z_high,
	output logic                     done,
	output logic signed [16:0]       normal_x,
	output logic signed [16:0]       normal_y,
	output logic signed [16:0]       normal_z,
	output logic signed [17:0]       tangent_x,
	output logic signed [17:0]       tangent_y,
	output logic signed [17:0]       tangent_z,
	output logic signed [17:0]       bitangent_x,
	output logic signed [17:0]       bitangent_y,
	output logic signed [17:0]       bitangent_z,
	output logic                     zero_normal_error
);
	localparam int FW  = wnf_pkg::FRAC_W;
	localparam int NW  = wnf_pkg::NORM_W;
	localparam int TW  = wnf_pkg::TAN_W;
	localparam int PW  = wnf_pkg::PROD_W;
	localparam int PPW = wnf_pkg::PROD_W - 1;
	localparam int RDW = wnf_pkg::RND_W;
	localparam int LAT = 5 + wnf_pkg::ROOT_W + 1 + wnf_pkg::QUO_W + 5;

	assign busy = 1'b0;

	// stage 1: differences as magnitude and sign
	logic                    vld_s1;
	logic [2:0][FW-1:0]      mag_s1;
	logic [2:0]              neg_s1;
	logic [2:0][FW-1:0]      lo_c, hi_c;
	logic [2:0][wnf_pkg::DIFF_W-1:0] diff_c;

	always_comb begin
		lo_c = {frac_z_low, frac_y_low, frac_x_low};
		hi_c = {frac_z_high, frac_y_high, frac_x_high};
		for (int i = 0; i < 3; i++) begin
			diff_c[i] = {1'b0, lo_c[i]} - {1'b0, hi_c[i]};
			if (i == 2 && DIMENSIONS < 3) diff_c[i] = '0;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			neg_s1[i] <= diff_c[i][wnf_pkg::DIFF_W-1];
			mag_s1[i] <= diff_c[i][wnf_pkg::DIFF_W-1] ? FW'(-diff_c[i]) : diff_c[i][FW-1:0];
		end
	end

	// stage 2: squares
	logic                            vld_s2;
	logic [2:0][FW-1:0]              mag_s2;
	logic [2:0]                      neg_s2;
	logic [2:0][wnf_pkg::SQ_W-1:0]   sq_s2;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			sq_s2[i] <= wnf_pkg::SQ_W'(mag_s1[i]) * wnf_pkg::SQ_W'(mag_s1[i]);
		end
		mag_s2 <= mag_s1;
		neg_s2 <= neg_s1;
	end

	// stage 3: squared length
	logic                       vld_s3;
	logic [2:0][FW-1:0]         mag_s3;
	logic [2:0]                 neg_s3;
	logic [wnf_pkg::SUM_W-1:0]  sum_s3;

	always_ff @(posedge clk) begin
		sum_s3 <= wnf_pkg::SUM_W'(sq_s2[0]) + wnf_pkg::SUM_W'(sq_s2[1])
			+ wnf_pkg::SUM_W'(sq_s2[2]);
		mag_s3 <= mag_s2;
		neg_s3 <= neg_s2;
	end

	// stage 4: find the even shift that lifts the length into the top pair
	logic                       vld_s4;
	logic [2:0][FW-1:0]         mag_s4;
	logic [2:0]                 neg_s4;
	logic [wnf_pkg::SUM_W-1:0]  sum_s4;
	logic [wnf_pkg::K_W-1:0]    k_s4;
	logic                       zero_s4;
	logic [wnf_pkg::K_W-1:0]    k_c;

	always_comb begin
		k_c = '0;
		for (int p = 0; p < wnf_pkg::SUM_W / 2; p++) begin
			if (sum_s3[2*p +: 2] != 2'b00) k_c = wnf_pkg::K_W'(30 - p);
		end
	end

	always_ff @(posedge clk) begin
		sum_s4  <= sum_s3;
		k_s4    <= k_c;
		zero_s4 <= sum_s3 == '0;
		mag_s4  <= mag_s3;
		neg_s4  <= neg_s3;
	end

	// stage 5: normalising shift
	logic                       vld_s5;
	logic [wnf_pkg::RAD_W-1:0]  rad_s5;
	wnf_pkg::side_a_t           side_s5;

	always_ff @(posedge clk) begin
		rad_s5       <= wnf_pkg::RAD_W'(sum_s4) << {k_s4, 1'b0};
		side_s5.mag  <= mag_s4;
		side_s5.neg  <= neg_s4;
		side_s5.k    <= k_s4;
		side_s5.zero <= zero_s4;
	end

	// square root
	logic                        sq_vld;
	logic [wnf_pkg::ROOT_W-1:0]  sq_root;
	wnf_pkg::side_a_t            sq_side;

	wnf_sqrt #(
		.TAG_W($bits(wnf_pkg::side_a_t))
	) u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (vld_s5),
		.rad    (rad_s5),
		.in_tag (side_s5),
		.out_vld(sq_vld),
		.root   (sq_root),
		.out_tag(sq_side)
	);

	// stage 6: rounded numerators
	logic                                                 vld_s6;
	logic [wnf_pkg::NUM_LANES-1:0][wnf_pkg::NUM_W-1:0]    num_s6;
	logic [wnf_pkg::ROOT_W-1:0]                           den_s6;
	wnf_pkg::side_b_t                                     side_s6;
	logic [5:0]                                           sh_c;
	logic [wnf_pkg::RAD_W-1:0]                            num_c [3];

	always_comb begin
		sh_c = 6'(sq_side.k) + 6'd15;
		for (int i = 0; i < 3; i++) begin
			num_c[i] = (wnf_pkg::RAD_W'(sq_side.mag[i]) << sh_c)
				+ wnf_pkg::RAD_W'(sq_root >> 1);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			num_s6[i] <= num_c[i][wnf_pkg::NUM_W-1:0];
		end
		den_s6       <= sq_root;
		side_s6.neg  <= sq_side.neg;
		side_s6.zero <= sq_side.zero;
	end

	// divider
	logic                                               dv_vld;
	logic [wnf_pkg::NUM_LANES-1:0][wnf_pkg::QUO_W-1:0]  dv_quot;
	wnf_pkg::side_b_t                                   dv_side;

	wnf_div #(
		.TAG_W($bits(wnf_pkg::side_b_t))
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (vld_s6),
		.num    (num_s6),
		.den    (den_s6),
		.in_tag (side_s6),
		.out_vld(dv_vld),
		.quot   (dv_quot),
		.out_tag(dv_side)
	);

	// stage 7: signed, clamped unit normal
	logic                        vld_s7;
	logic signed [2:0][NW-1:0]   n_s7;
	logic                        zero_s7;
	logic [wnf_pkg::QUO_W-1:0]   qc_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			qc_c[i] = (dv_quot[i] > wnf_pkg::QUO_W'(wnf_pkg::NMAX))
				? wnf_pkg::QUO_W'(wnf_pkg::NMAX) : dv_quot[i];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			n_s7[i] <= dv_side.neg[i] ? NW'(-qc_c[i]) : NW'(qc_c[i]);
		end
		zero_s7 <= dv_side.zero;
	end

	// stage 8: tangent products
	logic                    vld_s8;
	logic signed [NW-1:0]    n_s8 [3];
	logic                    zero_s8;
	logic signed [TW-1:0]    gh_s8;
	logic signed [PW-2:0]    p_s8 [3];
	logic signed [NW-1:0]    n0_c, n1_c, n2_c;
	logic signed [TW-1:0]    h_c;

	always_comb begin
		n0_c = n_s7[0];
		n1_c = n_s7[1];
		n2_c = n_s7[2];
		h_c  = (n2_c >= 0) ? TW'(n2_c) + TW'(wnf_pkg::ONE_Q15)
			: TW'(n2_c) - TW'(wnf_pkg::ONE_Q15);
	end

	always_ff @(posedge clk) begin
		n_s8[0] <= n0_c;
		n_s8[1] <= n1_c;
		n_s8[2] <= n2_c;
		zero_s8 <= zero_s7;
		gh_s8   <= ((n2_c >= 0) ? TW'(n2_c) : -TW'(n2_c)) + TW'(wnf_pkg::ONE_Q15);
		p_s8[0] <= PPW'(n0_c) * PPW'(n0_c);
		p_s8[1] <= PPW'(n0_c) * PPW'(n1_c);
		p_s8[2] <= PPW'(n0_c) * PPW'(h_c);
	end

	// stage 9: tangent
	logic                    vld_s9;
	logic signed [NW-1:0]    n_s9 [3];
	logic signed [TW-1:0]    t_s9 [3];
	logic                    zero_s9;
	logic signed [TW-1:0]    t_c [3];

	always_comb begin
		if (DIMENSIONS == 2) begin
			t_c[0] = -TW'(n_s8[1]);
			t_c[1] = TW'(n_s8[0]);
			t_c[2] = '0;
		end else begin
			t_c[0] = wnf_pkg::sat_t(RDW'(gh_s8) - wnf_pkg::rq15(PW'(p_s8[0])));
			t_c[1] = wnf_pkg::sat_t(-wnf_pkg::rq15(PW'(p_s8[1])));
			t_c[2] = wnf_pkg::sat_t(-wnf_pkg::rq15(PW'(p_s8[2])));
		end
	end

	always_ff @(posedge clk) begin
		n_s9    <= n_s8;
		t_s9    <= t_c;
		zero_s9 <= zero_s8;
	end

	// stage 10: cross-product terms
	logic                    vld_s10;
	logic signed [NW-1:0]    n_s10 [3];
	logic signed [TW-1:0]    t_s10 [3];
	logic                    zero_s10;
	logic signed [PW-2:0]    pb_s10 [6];

	always_ff @(posedge clk) begin
		pb_s10[0] <= PPW'(n_s9[1]) * PPW'(t_s9[2]);
		pb_s10[1] <= PPW'(n_s9[2]) * PPW'(t_s9[1]);
		pb_s10[2] <= PPW'(n_s9[2]) * PPW'(t_s9[0]);
		pb_s10[3] <= PPW'(n_s9[0]) * PPW'(t_s9[2]);
		pb_s10[4] <= PPW'(n_s9[0]) * PPW'(t_s9[1]);
		pb_s10[5] <= PPW'(n_s9[1]) * PPW'(t_s9[0]);
		n_s10     <= n_s9;
		t_s10     <= t_s9;
		zero_s10  <= zero_s9;
	end

	// stage 11: bitangent and result register, all zero on a zero-length normal
	logic signed [TW-1:0] b_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			b_c[i] = wnf_pkg::sat_t(wnf_pkg::rq15(PW'(pb_s10[2*i]) - PW'(pb_s10[2*i+1])));
		end
	end

	always_ff @(posedge clk) begin
		normal_x          <= zero_s10 ? '0 : n_s10[0];
		normal_y          <= zero_s10 ? '0 : n_s10[1];
		normal_z          <= zero_s10 ? '0 : n_s10[2];
		tangent_x         <= zero_s10 ? '0 : t_s10[0];
		tangent_y         <= zero_s10 ? '0 : t_s10[1];
		tangent_z         <= zero_s10 ? '0 : t_s10[2];
		bitangent_x       <= zero_s10 ? '0 : b_c[0];
		bitangent_y       <= zero_s10 ? '0 : b_c[1];
		bitangent_z       <= zero_s10 ? '0 : b_c[2];
		zero_normal_error <= zero_s10;
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			done    <= 1'b0;
		end else begin
			vld_s1  <= start && !busy;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= sq_vld;
			vld_s7  <= dv_vld;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			done    <= vld_s10;
		end
	end

	// every accepted item comes out a fixed latency later
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LAT done)
		else $error("item lost in pipeline");

	// an error result carries an all-zero frame
	a_zero_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(done && zero_normal_error) |-> (normal_x == 0 && normal_y == 0 && normal_z == 0
			&& tangent_x == 0 && bitangent_z == 0))
		else $error("error result not cleared");

	// normal x and z stay within Q1.15 limits
	a_norm_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (normal_x <= 17'sd32768 && normal_x >= -17'sd32768
			&& normal_z <= 17'sd32768 && normal_z >= -17'sd32768))
		else $error("normal out of range");

endmodule
`default_nettype wire
